// ----- rtl/core/rotation_from_angle_axis_defines.svh -----
// Assertion macros for the rotation block.
`ifndef ROTATION_FROM_ANGLE_AXIS_DEFINES_SVH
`define ROTATION_FROM_ANGLE_AXIS_DEFINES_SVH
`ifndef SYNTH
`define RFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define RFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define RFA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/rfa_pkg.sv -----
// Package: widths, CORDIC constants and arctangent table.
package rfa_pkg;
	localparam int CORDIC_STAGES = 16;
	localparam int FRAC_BITS = 14;
	localparam int WORK_FRAC = 30;
	localparam int ANGLE_FRAC = 13;
	localparam int WW = 34;
	localparam int TABLE_LEN = 24;
	localparam int IDXW = $clog2(TABLE_LEN);
	localparam logic signed [WW-1:0] PI_W = 34'sd3373259426;
	localparam logic signed [WW-1:0] HALF_PI_W = 34'sd1686629713;
	localparam logic signed [WW-1:0] GAIN_W = 34'sd652032874;
	localparam logic signed [WW-1:0] ONE_W = 34'sd1073741824;

	typedef logic signed [WW-1:0] work_t;
	typedef logic signed [15:0] word_t;

	typedef struct packed {
		logic vld;
		logic flip;
		work_t x;
		work_t y;
		work_t z;
		word_t ax;
		word_t ay;
		word_t az;
	} cell_t;

	function automatic work_t atan_w(input logic [IDXW-1:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'h3243F6A8; 5'd1: r = 32'h1DAC6705; 5'd2: r = 32'h0FADBAFC;
			5'd3: r = 32'h07F56EA6; 5'd4: r = 32'h03FEAB76; 5'd5: r = 32'h01FFD55B;
			5'd6: r = 32'h00FFFAAA; 5'd7: r = 32'h007FFF55; 5'd8: r = 32'h003FFFEA;
			5'd9: r = 32'h001FFFFD; 5'd10: r = 32'h000FFFFF; 5'd11: r = 32'h0007FFFF;
			5'd12: r = 32'h0003FFFF; 5'd13: r = 32'h0001FFFF; 5'd14: r = 32'h0000FFFF;
			5'd15: r = 32'h00007FFF; 5'd16: r = 32'h00003FFF; 5'd17: r = 32'h00001FFF;
			5'd18: r = 32'h00000FFF; 5'd19: r = 32'h000007FF; 5'd20: r = 32'h000003FF;
			5'd21: r = 32'h000001FF; 5'd22: r = 32'h000000FF; 5'd23: r = 32'h0000007F;
			default: r = 32'h0;
		endcase
		return work_t'({2'b00, r});
	endfunction
endpackage

// ----- rtl/core/rfa_cell.sv -----
// One CORDIC rotation cell: a micro-rotation plus a register to the next cell.
module rfa_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [rfa_pkg::IDXW-1:0] stage,
	input  rfa_pkg::cell_t           d,
	output rfa_pkg::cell_t           q
);
	rfa_pkg::cell_t n;
	rfa_pkg::work_t dx, dy;
	always_comb begin
		dx = d.y >>> stage;
		dy = d.x >>> stage;
		n = d;
		if (!d.z[rfa_pkg::WW-1]) begin
			n.x = d.x - dx;
			n.y = d.y + dy;
			n.z = d.z - rfa_pkg::atan_w(stage);
		end else begin
			n.x = d.x + dx;
			n.y = d.y - dy;
			n.z = d.z + rfa_pkg::atan_w(stage);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) q <= '0;
		else q <= n;
	end
endmodule

// ----- rtl/core/rfa_matrix.sv -----
// Matrix back end: products, Rodrigues sums, rounding and saturation.
module rfa_matrix (
	input  logic              clk,
	input  logic              arst_n,
	input  rfa_pkg::cell_t    d,
	output logic              vld,
	output rfa_pkg::word_t    e [9]
);
	localparam int F = rfa_pkg::FRAC_BITS;
	localparam int WF = rfa_pkg::WORK_FRAC;
	logic signed [33:0] s_c, v_c;
	logic signed [33:0] s_s1, v_s1;
	logic signed [32:0] pp_s1 [9];
	logic signed [16:0] u_s1 [9];
	logic signed [33:0] t_s2 [9];
	logic signed [51:0] su_s2 [9];
	logic signed [33:0] v_s2;
	logic [2:0] vld_q;
	logic signed [33:0] sc, cc;
	logic signed [16:0] x, y, z;
	logic signed [32:0] xx, yy, zz;

	always_comb begin
		sc = d.flip ? -d.y : d.y;
		cc = d.flip ? -d.x : d.x;
		s_c = (sc > rfa_pkg::ONE_W) ? rfa_pkg::ONE_W : (sc < -rfa_pkg::ONE_W) ? -rfa_pkg::ONE_W : sc;
		cc = (cc > rfa_pkg::ONE_W) ? rfa_pkg::ONE_W : (cc < -rfa_pkg::ONE_W) ? -rfa_pkg::ONE_W : cc;
		v_c = rfa_pkg::ONE_W - cc;
		x = 17'(d.ax); y = 17'(d.ay); z = 17'(d.az);
		xx = 33'(x * x); yy = 33'(y * y); zz = 33'(z * z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[1:0], d.vld};
	end

	always_ff @(posedge clk) begin
		s_s1 <= s_c; v_s1 <= v_c;
		pp_s1[0] <= -(yy + zz); pp_s1[4] <= -(xx + zz); pp_s1[8] <= -(xx + yy);
		pp_s1[1] <= 33'(x * y); pp_s1[3] <= 33'(x * y);
		pp_s1[2] <= 33'(x * z); pp_s1[6] <= 33'(x * z);
		pp_s1[5] <= 33'(y * z); pp_s1[7] <= 33'(y * z);
		u_s1[0] <= '0; u_s1[4] <= '0; u_s1[8] <= '0;
		u_s1[1] <= -z; u_s1[2] <= y; u_s1[3] <= z;
		u_s1[5] <= -x; u_s1[6] <= -y; u_s1[7] <= x;
	end

	always_ff @(posedge clk) begin
		v_s2 <= v_s1;
		for (int i = 0; i < 9; i++) begin
			su_s2[i] <= 52'(s_s1 * u_s1[i]);
			t_s2[i] <= 34'(pp_s1[i]);
		end
	end

	logic signed [69:0] vp [9];
	logic signed [69:0] sum [9];
	logic signed [69:0] r [9];
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			vp[i] = (70'(v_s2) * 70'(t_s2[i]) + 70'(1 <<< (F - 1))) >>> F;
			sum[i] = 70'(su_s2[i]) + vp[i] + 70'(1 <<< (WF - 1));
			if (i == 0 || i == 4 || i == 8) sum[i] = sum[i] + (70'sd1 <<< (WF + F));
			r[i] = sum[i] >>> WF;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++)
			e[i] <= (r[i] > 70'sd32767) ? 16'sh7FFF : (r[i] < -70'sd32768) ? 16'sh8000 : 16'(r[i]);
	end
	assign vld = vld_q[2];
endmodule

// ----- rtl/core/rotation_from_angle_axis.sv -----
// Top level: Rodrigues rotation matrix from angle and axis.
// Usage: drive angle and axis_x/y/z with start high for one cycle; busy is
// always low, so a new transaction may start in every cycle.
// The angle enters a row of CORDIC_STAGES registered rotation cells,
// then three matrix stages (products, Rodrigues sums, round and saturate).
// Throughput: one transaction per cycle, set by the fully pipelined cell row.
// done is high for one cycle with all nine entries; the receiver cannot
// stall, so results must be taken in that cycle.
// Reset clears all valid bits; transactions in flight are dropped.
`include "rotation_from_angle_axis_defines.svh"
module rotation_from_angle_axis (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] angle,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	output logic               done,
	output logic signed [15:0] entry_r0c0,
	output logic signed [15:0] entry_r0c1,
	output logic signed [15:0] entry_r0c2,
	output logic signed [15:0] entry_r1c0,
	output logic signed [15:0] entry_r1c1,
	output logic signed [15:0] entry_r1c2,
	output logic signed [15:0] entry_r2c0,
	output logic signed [15:0] entry_r2c1,
	output logic signed [15:0] entry_r2c2
);
	localparam int N = rfa_pkg::CORDIC_STAGES;
	rfa_pkg::cell_t head;
	rfa_pkg::cell_t in_s1;
	rfa_pkg::work_t za;
	rfa_pkg::word_t e [9];
	rfa_pkg::cell_t row [N+1];

	assign busy = 1'b0;
	always_comb begin
		za = rfa_pkg::work_t'(angle) <<< (rfa_pkg::WORK_FRAC - rfa_pkg::ANGLE_FRAC);
		head.vld = start;
		head.flip = 1'b0;
		head.x = rfa_pkg::GAIN_W;
		head.y = '0;
		head.z = za;
		if (za > rfa_pkg::HALF_PI_W) begin
			head.z = za - rfa_pkg::PI_W; head.flip = 1'b1;
		end else if (za < -rfa_pkg::HALF_PI_W) begin
			head.z = za + rfa_pkg::PI_W; head.flip = 1'b1;
		end
		head.ax = axis_x; head.ay = axis_y; head.az = axis_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) in_s1 <= '0;
		else in_s1 <= head;
	end

	assign row[0] = in_s1;
	for (genvar g = 0; g < N; g++) begin : g_cell
		rfa_cell u_cell (.clk(clk), .arst_n(arst_n), .stage(rfa_pkg::IDXW'(g)),
			.d(row[g]), .q(row[g+1]));
	end

	rfa_matrix u_matrix (.clk(clk), .arst_n(arst_n), .d(row[N]), .vld(done), .e(e));

	assign entry_r0c0 = e[0]; assign entry_r0c1 = e[1]; assign entry_r0c2 = e[2];
	assign entry_r1c0 = e[3]; assign entry_r1c1 = e[4]; assign entry_r1c2 = e[5];
	assign entry_r2c0 = e[6]; assign entry_r2c1 = e[7]; assign entry_r2c2 = e[8];

	`RFA_ASSERT_NEXT(a_start_enters, clk, arst_n, start, in_s1.vld)
	`RFA_ASSERT_IMPL(a_never_busy, clk, arst_n, 1'b1, !busy)
	`RFA_ASSERT_IMPL(a_row_tail, clk, arst_n, row[N].vld, $past(in_s1.vld, N))
endmodule
